// ===== rtl/core/qau_pkg.sv =====
package qau_pkg;

    // fixed point format
    localparam int FRAC_BITS  = 27;
    localparam int NORM_GUARD = 31;
    localparam int DIV_SH     = FRAC_BITS;
    localparam int NORM_SH    = FRAC_BITS + NORM_GUARD;

    // datapath widths
    localparam int PW  = 64;                 // one 32x32 product
    localparam int AW  = PW + 2;             // sum of four products
    localparam int SW  = PW + 1;             // sum of squares, divisor
    localparam int QW  = 33;                 // quotient bits kept
    localparam int DW  = (SW + DIV_SH > 33 + NORM_SH) ? SW + DIV_SH : 33 + NORM_SH;
    localparam int XW  = 2 * ((SW + 2 * NORM_GUARD + 1) / 2);   // radicand, even
    localparam int RB  = XW / 2;             // root bits
    localparam int SRW = RB + 2;             // root remainder

    // operation codes
    localparam logic [2:0] K_MUL   = 3'd0;
    localparam logic [2:0] K_DIV   = 3'd1;
    localparam logic [2:0] K_ADD   = 3'd2;
    localparam logic [2:0] K_SUB   = 3'd3;
    localparam logic [2:0] K_SCALE = 3'd4;
    localparam logic [2:0] K_NORM  = 3'd5;
    localparam logic [2:0] K_CONJ  = 3'd6;
    localparam logic [2:0] K_NEG   = 3'd7;

    // negated terms, bit index = component*4 + left index
    localparam logic [15:0] MUL_NEG = 16'h428E;
    localparam logic [15:0] DIV_NEG = 16'h3950;

    // everything that rides alongside the divider
    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0][31:0] res;
        logic             sat;
        logic             zero;
    } t_side;

    function automatic logic signed [PW-1:0] mul32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return a * b;
    endfunction

    // drop the fraction, round to nearest with ties up
    function automatic logic signed [67:0] rnd_frac(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + (68'sd1 <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    // clip to 32 bits, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -68'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

// ===== rtl/core/qau_front.sv =====
module qau_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [2:0]                     i_kind,
    input  logic [3:0][31:0]               i_left,
    input  logic [3:0][31:0]               i_right,
    output logic                           o_valid,
    output qau_pkg::t_side                 o_side,
    output logic [qau_pkg::SW-1:0]         o_sq,
    output logic [3:0][qau_pkg::DW-1:0]    o_dvd,
    output logic [3:0]                     o_neg
);

    // stage 1: input capture
    logic                r1_vld;
    logic [2:0]          r1_kind;
    logic [3:0][31:0]    r1_l, r1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_kind;
            r1_l    <= i_left;
            r1_r    <= i_right;
        end
    end

    // stage 2: all cross products and the squares
    logic                                 r2_vld;
    logic [2:0]                           r2_kind;
    logic [3:0][31:0]                     r2_l, r2_r;
    logic [3:0][3:0][qau_pkg::PW-1:0]     r2_p, n2_p;
    logic [3:0][qau_pkg::PW-1:0]          r2_q, n2_q;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 4; j++) begin
                n2_p[k][j] = qau_pkg::mul32(r1_l[k], r1_r[j]);
            end
            if (r1_kind == qau_pkg::K_DIV) begin
                n2_q[k] = qau_pkg::mul32(r1_r[k], r1_r[k]);
            end else begin
                n2_q[k] = qau_pkg::mul32(r1_l[k], r1_l[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_kind <= r1_kind;
            r2_l    <= r1_l;
            r2_r    <= r1_r;
            r2_p    <= n2_p;
            r2_q    <= n2_q;
        end
    end

    // stage 3: signed sums of products, norm
    logic                             r3_vld;
    logic [2:0]                       r3_kind;
    logic [3:0][31:0]                 r3_l, r3_r;
    logic [3:0][qau_pkg::AW-1:0]      r3_acc, n3_acc;
    logic [3:0][qau_pkg::PW-1:0]      r3_scl;
    logic [qau_pkg::SW-1:0]           r3_sq, n3_sq;

    always_comb begin
        logic [qau_pkg::AW-1:0] term;
        logic [15:0]            negs;
        negs  = (r2_kind == qau_pkg::K_DIV) ? qau_pkg::DIV_NEG : qau_pkg::MUL_NEG;
        n3_sq = '0;
        for (int i = 0; i < 4; i++) begin
            n3_acc[i] = '0;
            for (int k = 0; k < 4; k++) begin
                term = {{2{r2_p[k][i ^ k][qau_pkg::PW-1]}}, r2_p[k][i ^ k]};
                if (negs[i * 4 + k]) begin
                    n3_acc[i] = n3_acc[i] - term;
                end else begin
                    n3_acc[i] = n3_acc[i] + term;
                end
            end
            n3_sq = n3_sq + {1'b0, r2_q[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_kind <= r2_kind;
            r3_l    <= r2_l;
            r3_r    <= r2_r;
            r3_acc  <= n3_acc;
            r3_sq   <= n3_sq;
            for (int i = 0; i < 4; i++) begin
                r3_scl[i] <= r2_p[i][0];
            end
        end
    end

    // stage 4: direct results, dividend magnitudes
    logic                         r4_vld;
    qau_pkg::t_side               r4_side, n4_side;
    logic [qau_pkg::SW-1:0]       r4_sq;
    logic [3:0][qau_pkg::DW-1:0]  r4_dvd, n4_dvd;
    logic [3:0]                   r4_neg, n4_neg;

    always_comb begin
        logic signed [67:0]     lx, rx, ax;
        logic [32:0]            sv;
        logic [qau_pkg::AW-1:0] amag;
        logic [32:0]            lmag;
        n4_side.kind = r3_kind;
        n4_side.sat  = 1'b0;
        n4_side.zero = (r3_sq == '0);
        for (int i = 0; i < 4; i++) begin
            lx = {{36{r3_l[i][31]}}, r3_l[i]};
            rx = {{36{r3_r[i][31]}}, r3_r[i]};
            ax = {{(68 - qau_pkg::AW){r3_acc[i][qau_pkg::AW-1]}}, r3_acc[i]};
            case (r3_kind)
                qau_pkg::K_MUL:   sv = qau_pkg::sat32(qau_pkg::rnd_frac(ax));
                qau_pkg::K_SCALE: sv = qau_pkg::sat32(qau_pkg::rnd_frac(
                                      {{(68 - qau_pkg::PW){r3_scl[i][qau_pkg::PW-1]}},
                                       r3_scl[i]}));
                qau_pkg::K_ADD:   sv = qau_pkg::sat32(lx + rx);
                qau_pkg::K_SUB:   sv = qau_pkg::sat32(lx - rx);
                qau_pkg::K_CONJ:  sv = (i == 0) ? {1'b0, r3_l[i]} : qau_pkg::sat32(-lx);
                qau_pkg::K_NEG:   sv = qau_pkg::sat32(-lx);
                qau_pkg::K_NORM:  sv = {1'b0, r3_l[i]};
                default:          sv = '0;
            endcase
            n4_side.res[i] = sv[31:0];
            n4_side.sat    = n4_side.sat | sv[32];

            // dividend: |acc| for div, |left| for normalise
            amag = r3_acc[i][qau_pkg::AW-1] ? -r3_acc[i] : r3_acc[i];
            lmag = r3_l[i][31] ? -{1'b1, r3_l[i]} : {1'b0, r3_l[i]};
            if (r3_kind == qau_pkg::K_DIV) begin
                n4_neg[i] = r3_acc[i][qau_pkg::AW-1];
                n4_dvd[i] = qau_pkg::DW'(amag) << qau_pkg::DIV_SH;
            end else begin
                n4_neg[i] = r3_l[i][31];
                n4_dvd[i] = qau_pkg::DW'(lmag) << qau_pkg::NORM_SH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side <= n4_side;
            r4_sq   <= r3_sq;
            r4_dvd  <= n4_dvd;
            r4_neg  <= n4_neg;
        end
    end

    assign o_valid = r4_vld;
    assign o_side  = r4_side;
    assign o_sq    = r4_sq;
    assign o_dvd   = r4_dvd;
    assign o_neg   = r4_neg;

endmodule

// ===== rtl/core/qau_sqrt.sv =====
module qau_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  qau_pkg::t_side                 i_side,
    input  logic [qau_pkg::SW-1:0]         i_sq,
    input  logic [3:0][qau_pkg::DW-1:0]    i_dvd,
    input  logic [3:0]                     i_neg,
    output logic                           o_valid,
    output qau_pkg::t_side                 o_side,
    output logic [3:0][qau_pkg::DW-1:0]    o_dvd,
    output logic [3:0]                     o_neg,
    output logic [qau_pkg::SW-1:0]         o_divisor
);

    localparam int RB  = qau_pkg::RB;
    localparam int XW  = qau_pkg::XW;
    localparam int SRW = qau_pkg::SRW;

    logic                         r_vld  [0:RB];
    qau_pkg::t_side               r_side [0:RB];
    logic [qau_pkg::SW-1:0]       r_sq   [0:RB];
    logic [3:0][qau_pkg::DW-1:0]  r_dvd  [0:RB];
    logic [3:0]                   r_neg  [0:RB];
    logic [XW-1:0]                r_x    [0:RB];
    logic [SRW-1:0]               r_rem  [0:RB];
    logic [RB-1:0]                r_root [0:RB];

    // load: radicand is the norm shifted up by twice the guard bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_sq[0]   <= i_sq;
            r_dvd[0]  <= i_dvd;
            r_neg[0]  <= i_neg;
            r_x[0]    <= XW'(i_sq) << (2 * qau_pkg::NORM_GUARD);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar s = 1; s <= RB; s++) begin : g_step
        logic [SRW+1:0] t, trial;

        always_comb begin
            t     = {r_rem[s-1], r_x[s-1][XW-1 -: 2]};
            trial = {2'b00, r_root[s-1], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= r_side[s-1];
                r_sq[s]   <= r_sq[s-1];
                r_dvd[s]  <= r_dvd[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_x[s]    <= r_x[s-1] << 2;
                if (t >= trial) begin
                    r_rem[s]  <= SRW'(t - trial);
                    r_root[s] <= {r_root[s-1][RB-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= t[SRW-1:0];
                    r_root[s] <= {r_root[s-1][RB-2:0], 1'b0};
                end
            end
        end
    end

    // divisor: root for normalise, norm for division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= r_side[RB];
            o_dvd  <= r_dvd[RB];
            o_neg  <= r_neg[RB];
            if (r_side[RB].kind == qau_pkg::K_NORM) begin
                o_divisor <= qau_pkg::SW'(r_root[RB]);
            end else begin
                o_divisor <= r_sq[RB];
            end
        end
    end

endmodule

// ===== rtl/core/qau_div.sv =====
module qau_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  qau_pkg::t_side                 i_side,
    input  logic [3:0][qau_pkg::DW-1:0]    i_dvd,
    input  logic [3:0]                     i_neg,
    input  logic [qau_pkg::SW-1:0]         i_divisor,
    output logic                           o_valid,
    output logic [3:0][31:0]               o_res,
    output logic                           o_sat,
    output logic                           o_derr
);

    localparam int QW = qau_pkg::QW;
    localparam int SW = qau_pkg::SW;

    logic                   r_vld  [0:QW];
    qau_pkg::t_side         r_side [0:QW];
    logic [SW-1:0]          r_d    [0:QW];
    logic [3:0]             r_neg  [0:QW];
    logic [3:0]             r_ovf  [0:QW];
    logic [3:0][SW-1:0]     r_rem  [0:QW];
    logic [3:0][QW-1:0]     r_low  [0:QW];
    logic [3:0][QW-1:0]     r_q    [0:QW];

    // load: top part of the dividend seeds the remainder, overflow check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_d[0]    <= i_divisor;
            r_neg[0]  <= i_neg;
            for (int i = 0; i < 4; i++) begin
                r_ovf[0][i] <= SW'(i_dvd[i][qau_pkg::DW-1:QW]) >= i_divisor;
                r_rem[0][i] <= SW'(i_dvd[i][qau_pkg::DW-1:QW]);
                r_low[0][i] <= i_dvd[i][QW-1:0];
                r_q[0][i]   <= '0;
            end
        end
    end

    // restoring division, one quotient bit per stage and lane
    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [3:0][SW:0] t;

        always_comb begin
            for (int i = 0; i < 4; i++) begin
                t[i] = {r_rem[s-1][i], r_low[s-1][i][QW-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= r_side[s-1];
                r_d[s]    <= r_d[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                for (int i = 0; i < 4; i++) begin
                    r_low[s][i] <= r_low[s-1][i] << 1;
                    if (t[i] >= {1'b0, r_d[s-1]}) begin
                        r_rem[s][i] <= SW'(t[i] - {1'b0, r_d[s-1]});
                        r_q[s][i]   <= {r_q[s-1][i][QW-2:0], 1'b1};
                    end else begin
                        r_rem[s][i] <= t[i][SW-1:0];
                        r_q[s][i]   <= {r_q[s-1][i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // round half away, apply sign, clip, pick the result by kind
    logic [3:0][31:0] n_res;
    logic             n_sat, n_derr;

    always_comb begin
        logic [3:0][31:0] dres;
        logic             dsat;
        logic             rup;
        logic [QW:0]      mag, nmag;
        qau_pkg::t_side   sd;
        sd   = r_side[QW];
        dsat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            rup  = {r_rem[QW][i], 1'b0} >= {1'b0, r_d[QW]};
            mag  = {1'b0, r_q[QW][i]} + (QW + 1)'(rup);
            nmag = -mag;
            if (r_ovf[QW][i]) begin
                dsat    = 1'b1;
                dres[i] = r_neg[QW][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (r_neg[QW][i]) begin
                if (mag > (QW + 1)'(33'h0_8000_0000)) begin
                    dsat    = 1'b1;
                    dres[i] = 32'h8000_0000;
                end else begin
                    dres[i] = nmag[31:0];
                end
            end else begin
                if (mag > (QW + 1)'(33'h0_7FFF_FFFF)) begin
                    dsat    = 1'b1;
                    dres[i] = 32'h7FFF_FFFF;
                end else begin
                    dres[i] = mag[31:0];
                end
            end
        end

        case (sd.kind)
            qau_pkg::K_DIV: begin
                n_derr = sd.zero;
                n_res  = sd.zero ? '0 : dres;
                n_sat  = sd.zero ? 1'b0 : dsat;
            end
            qau_pkg::K_NORM: begin
                n_derr = 1'b0;
                n_res  = sd.zero ? sd.res : dres;
                n_sat  = sd.zero ? sd.sat : dsat;
            end
            default: begin
                n_derr = 1'b0;
                n_res  = sd.res;
                n_sat  = sd.sat;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res  <= n_res;
            o_sat  <= n_sat;
            o_derr <= n_derr;
        end
    end

endmodule

// ===== rtl/core/quaternion_arithmetic_unit.sv =====
// Channel   Dir  Word
// s_axis    in   tdata: left w,x,y,z, right w,x,y,z (32 b each); tuser: kind
// m_axis    out  tdata: out w,x,y,z (32 b each); tuser: saturated, divide_error
//
// One word enters every cycle while the output is not held; each word passes
// the front end, the 64-stage square root and then the 33-stage divider.
// Reset is synchronous, active low, and empties the pipeline valid bits.
// The whole pipeline holds while a result sits unaccepted at the output,
// so s_axis_tready follows that output register.
module quaternion_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [255:0]  s_axis_tdata,   // left_w, left_x, left_y, left_z,
                                          // right_w, right_x, right_y, right_z
    input  logic [2:0]    s_axis_tuser,   // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // out_w, out_x, out_y, out_z
    output logic [1:0]    m_axis_tuser    // saturated, divide_error
);

    logic                           w_en;
    logic [3:0][31:0]               w_left, w_right;

    logic                           w_f_vld;
    qau_pkg::t_side                 w_f_side;
    logic [qau_pkg::SW-1:0]         w_f_sq;
    logic [3:0][qau_pkg::DW-1:0]    w_f_dvd;
    logic [3:0]                     w_f_neg;

    logic                           w_s_vld;
    qau_pkg::t_side                 w_s_side;
    logic [3:0][qau_pkg::DW-1:0]    w_s_dvd;
    logic [3:0]                     w_s_neg;
    logic [qau_pkg::SW-1:0]         w_s_divisor;

    logic                           w_o_vld;
    logic [3:0][31:0]               w_o_res;
    logic                           w_o_sat, w_o_derr;

    // global advance: output empty or being taken
    assign w_en          = !w_o_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_left  = s_axis_tdata[127:0];
    assign w_right = s_axis_tdata[255:128];

    qau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .i_left  (w_left),
        .i_right (w_right),
        .o_valid (w_f_vld),
        .o_side  (w_f_side),
        .o_sq    (w_f_sq),
        .o_dvd   (w_f_dvd),
        .o_neg   (w_f_neg)
    );

    qau_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_f_vld),
        .i_side    (w_f_side),
        .i_sq      (w_f_sq),
        .i_dvd     (w_f_dvd),
        .i_neg     (w_f_neg),
        .o_valid   (w_s_vld),
        .o_side    (w_s_side),
        .o_dvd     (w_s_dvd),
        .o_neg     (w_s_neg),
        .o_divisor (w_s_divisor)
    );

    qau_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_s_vld),
        .i_side    (w_s_side),
        .i_dvd     (w_s_dvd),
        .i_neg     (w_s_neg),
        .i_divisor (w_s_divisor),
        .o_valid   (w_o_vld),
        .o_res     (w_o_res),
        .o_sat     (w_o_sat),
        .o_derr    (w_o_derr)
    );

    assign m_axis_tvalid = w_o_vld;
    assign m_axis_tdata  = w_o_res;
    assign m_axis_tuser  = {w_o_derr, w_o_sat};

    // a divide error always comes with a zero word
    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("divide error with nonzero data");

    // a divide error never also reports clipping
    a_derr_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("divide error with saturation");

    // input stalls only behind a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a held output word keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed under stall");

endmodule

// ===== tb/quaternion_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps

// Scoreboard: computes expected results for accepted words, checks outputs in order
class qau_scoreboard;
    typedef struct {
        logic [3:0][31:0] comp;
        logic             sat;
        logic             derr;
    } t_qres;

    t_qres       pending[$];
    int          mismatches;

    function new();
        mismatches = 0;
    endfunction

    // round to nearest, ties up, dropping FRAC_BITS
    static function logic signed [127:0] drop_frac(logic signed [127:0] v);
        return (v + (128'sd1 <<< (qau_pkg::FRAC_BITS - 1))) >>> qau_pkg::FRAC_BITS;
    endfunction

    // unsigned quotient, ties away from zero
    static function logic [255:0] udiv_round(logic [255:0] n, logic [255:0] d);
        logic [255:0] q;
        logic [255:0] r;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 1;
        return q;
    endfunction

    // sign applied after rounding the magnitude
    static function logic signed [255:0] sdiv_shift(logic signed [255:0] num, int sh,
                                                    logic [255:0] d);
        logic [255:0] mag;
        logic [255:0] q;
        mag = num[255] ? -num : num;
        q = udiv_round(mag << sh, d);
        return num[255] ? -$signed(q) : $signed(q);
    endfunction

    static function logic [255:0] isqrt(logic [255:0] n);
        logic [255:0] lo;
        logic [255:0] hi;
        logic [255:0] mid;
        lo = 0;
        hi = 256'd1 << 64;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    static function logic [31:0] clip(logic signed [255:0] v, inout logic sat);
        if (v > 256'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -256'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // expected result of one quaternion operation
    function void note_word(logic [2:0] kind, logic [255:0] data);
        logic signed [255:0] lq[4];
        logic signed [255:0] rq[4];
        logic signed [255:0] acc;
        logic [255:0]        norm;
        t_qres               e;
        int                  sgn;
        for (int i = 0; i < 4; i++) begin
            lq[i] = $signed(data[32*i +: 32]);
            rq[i] = $signed(data[128 + 32*i +: 32]);
        end
        e.sat  = 1'b0;
        e.derr = 1'b0;
        case (kind)
            qau_pkg::K_MUL, qau_pkg::K_DIV: begin
                norm = 0;
                for (int k = 0; k < 4; k++) norm += rq[k] * rq[k];
                if (kind == qau_pkg::K_DIV && norm == 0) begin
                    e.derr = 1'b1;
                    e.comp = '0;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++) begin
                            sgn = (kind == qau_pkg::K_MUL) ? qau_pkg::MUL_NEG[i*4+k]
                                                           : qau_pkg::DIV_NEG[i*4+k];
                            if (sgn) acc -= lq[k] * rq[i ^ k];
                            else acc += lq[k] * rq[i ^ k];
                        end
                        if (kind == qau_pkg::K_MUL)
                            e.comp[i] = clip(drop_frac(acc[127:0]), e.sat);
                        else
                            e.comp[i] = clip(sdiv_shift(acc, qau_pkg::FRAC_BITS, norm), e.sat);
                    end
                end
            end
            qau_pkg::K_ADD:
                for (int i = 0; i < 4; i++) e.comp[i] = clip(lq[i] + rq[i], e.sat);
            qau_pkg::K_SUB:
                for (int i = 0; i < 4; i++) e.comp[i] = clip(lq[i] - rq[i], e.sat);
            qau_pkg::K_SCALE:
                for (int i = 0; i < 4; i++) begin
                    acc = lq[i] * rq[0];
                    e.comp[i] = clip(drop_frac(acc[127:0]), e.sat);
                end
            qau_pkg::K_NORM: begin
                norm = 0;
                for (int k = 0; k < 4; k++) norm += lq[k] * lq[k];
                if (norm == 0) begin
                    e.comp = '0;
                end else begin
                    norm = isqrt(norm << (2 * qau_pkg::NORM_GUARD));
                    for (int i = 0; i < 4; i++)
                        e.comp[i] = clip(sdiv_shift(lq[i],
                            qau_pkg::FRAC_BITS + qau_pkg::NORM_GUARD, norm), e.sat);
                end
            end
            qau_pkg::K_CONJ: begin
                e.comp[0] = lq[0][31:0];
                for (int i = 1; i < 4; i++) e.comp[i] = clip(-lq[i], e.sat);
            end
            default:
                for (int i = 0; i < 4; i++) e.comp[i] = clip(-lq[i], e.sat);
        endcase
        pending.push_back(e);
    endfunction

    // compare one output word with the oldest expectation
    function void check_word(logic [127:0] data, logic [1:0] user);
        t_qres e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output word %h", data);
            return;
        end
        e = pending.pop_front();
        if (data !== e.comp || user[0] !== e.sat || user[1] !== e.derr) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %h sat %b derr %b, got %h sat %b derr %b",
                         e.comp, e.sat, e.derr, data, user[0], user[1]);
        end
    endfunction
endclass

module quaternion_arithmetic_unit_tb;

    localparam int MAX_CYCLES = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;    // left w,x,y,z, right w,x,y,z
    logic [2:0]   s_axis_tuser = '0;    // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // out w,x,y,z
    logic [1:0]   m_axis_tuser;         // saturated, divide_error

    qau_scoreboard sb = new();
    int  cycle_cnt = 0;
    bit  rx_idle_on = 1'b1;
    bit  hold_rx = 1'b0;

    quaternion_arithmetic_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("** quaternion_arithmetic_unit: FAILED **");
            $finish;
        end
    end

    // accepted words on both sides
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
    end

    // receiver: random stalls, or a long hold-off
    always @(posedge i_clk) begin
        if (hold_rx) m_axis_tready <= 1'b0;
        else if (rx_idle_on) m_axis_tready <= ($urandom_range(99) >= 20);
        else m_axis_tready <= 1'b1;
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(2 * 2**27) - 2**27;  // around +-1.0
            default: return $urandom();
        endcase
    endfunction

    // offer one word and wait until it is taken
    task automatic send_word(logic [2:0] kind, logic [255:0] data, bit idle_on);
        while (idle_on && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_quat(logic [2:0] kind, logic [3:0][31:0] lq, logic [3:0][31:0] rq,
                             bit idle_on);
        send_word(kind, {rq, lq}, idle_on);
    endtask

    task automatic send_random(int n, bit idle_on);
        logic [3:0][31:0] lq;
        logic [3:0][31:0] rq;
        for (int j = 0; j < n; j++) begin
            for (int i = 0; i < 4; i++) begin
                lq[i] = rand_comp();
                rq[i] = rand_comp();
            end
            if ($urandom_range(9) == 0) rq = '0;
            if ($urandom_range(19) == 0) lq = '0;
            send_quat(3'($urandom_range(7)), lq, rq, idle_on);
        end
    endtask

    localparam logic [31:0] ONE  = 32'h0800_0000;
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] ZERO = 32'h0000_0000;
    localparam logic [31:0] ONES = 32'hFFFF_FFFF;

    initial begin
        int wait_cnt;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each kind, extremes, zero-norm divide, zero-length normalize
        for (int k = 0; k < 8; k++)
            send_quat(k[2:0], {32'd3, ONE, MINV, MAXV}, {ONE, 32'hF800_0000, 32'd5, ONE}, 1'b1);
        send_quat(qau_pkg::K_DIV, {ONE, ONE, ONE, ONE}, '0, 1'b1);
        send_quat(qau_pkg::K_NORM, '0, {MAXV, MAXV, MAXV, MAXV}, 1'b1);
        send_quat(qau_pkg::K_NEG, {MINV, MINV, MINV, MINV}, '0, 1'b1);
        send_quat(qau_pkg::K_CONJ, {MINV, MINV, MINV, MINV}, '0, 1'b1);
        send_quat(qau_pkg::K_MUL, {MINV, MINV, MINV, MINV}, {MINV, MINV, MINV, MINV}, 1'b1);
        send_quat(qau_pkg::K_MUL, {MAXV, MAXV, MAXV, MAXV}, {MINV, MAXV, MINV, MAXV}, 1'b1);
        send_quat(qau_pkg::K_ADD, {MAXV, MINV, MAXV, MINV}, {MAXV, MINV, 32'd1, ONES}, 1'b1);
        send_quat(qau_pkg::K_SUB, {MAXV, MINV, MAXV, MINV}, {MINV, MAXV, ZERO, ZERO}, 1'b1);
        send_quat(qau_pkg::K_SCALE, {MAXV, MINV, ONE, 32'd1}, {ONES, ONES, ONES, MINV}, 1'b1);
        send_quat(qau_pkg::K_DIV, {MAXV, MINV, MAXV, MINV}, {ZERO, ZERO, ZERO, 32'd1}, 1'b1);
        send_quat(qau_pkg::K_NORM, {ZERO, ZERO, ZERO, 32'd1}, '0, 1'b1);
        send_quat(qau_pkg::K_NORM, {MINV, MINV, MINV, MINV}, '0, 1'b1);
        send_quat(qau_pkg::K_DIV, {ZERO, ZERO, ZERO, ONE}, {ZERO, ZERO, ONES, ZERO}, 1'b1);

        // random with idling
        send_random(150, 1'b1);

        // long receiver hold-off while the sender keeps pushing
        hold_rx = 1'b1;
        fork
            send_random(150, 1'b0);
            begin
                for (wait_cnt = 0; wait_cnt < 300; wait_cnt++) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join

        // no idling on either side
        rx_idle_on = 1'b0;
        send_random(80, 1'b0);
        rx_idle_on = 1'b1;
        send_random(20, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("** quaternion_arithmetic_unit: PASSED **");
        end else begin
            $display("** quaternion_arithmetic_unit: FAILED **");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/qau_pkg.sv
rtl/core/qau_front.sv
rtl/core/qau_sqrt.sv
rtl/core/qau_div.sv
rtl/core/quaternion_arithmetic_unit.sv
tb/quaternion_arithmetic_unit_tb.sv
